FILE: sv/obpq_pkg.sv
// Shared types and constants for the oriented box point query pipeline.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package obpq_pkg;

    // Register stages from input register to output register.
    localparam int unsigned NUM_STAGES = 8;
    localparam int unsigned XF_STAGES  = 3;
    localparam int unsigned RS_STAGES  = 2;
    localparam int unsigned FN_STAGES  = 3;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_ANGLE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_ANGLE  = 3'd5;

    localparam logic [62:0] DIST_MAX      = {63{1'b1}};
    localparam logic [17:0] COS_RESET     = 18'sd65536;
    localparam logic [31:0] TARGET_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] TARGET_NEG_MAX = 32'h8000_0000;

    typedef struct packed {
        logic signed [31:0] query_x;
        logic signed [31:0] query_y;
        logic        [30:0] agent_radius;
    } t_in;

    typedef struct packed {
        logic               inside_res;
        logic        [62:0] dist_squared;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
    } t_out;

    typedef struct packed {
        logic signed [31:0] pivot_x;
        logic signed [31:0] pivot_y;
        logic        [30:0] box_width;
        logic        [30:0] box_height;
        logic signed [17:0] cos_angle;
        logic signed [17:0] sin_angle;
    } t_cfg;

    // Point in box space (Q32.32) plus per-axis inset bounds.
    typedef struct packed {
        logic signed [51:0] lx;
        logic signed [51:0] ly;
        logic               small_x;
        logic               small_y;
        logic        [30:0] hi_x;
        logic        [30:0] hi_y;
        logic        [30:0] radius;
    } t_local;

    // Rounded gaps and local target (Q16.16).
    typedef struct packed {
        logic        in_box;
        logic [36:0] ex;
        logic [36:0] ey;
        logic [30:0] tx;
        logic [30:0] ty;
    } t_resolved;

endpackage

`default_nettype wire

FILE: sv/oriented_box_point_query_top.sv
// Oriented box point query. Throughput is one query per cycle unless the output is
// stalled; the eight register stages advance independently, so a stage with no
// valid item takes a new one even while the output is stalled.
// Reset (synchronous, active low) clears all stage valid bits and loads the box
// registers with pivot 0, size 0, cosine 1.0, sine 0.
`timescale 1ns / 1ps
`default_nettype none

module oriented_box_point_query_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire obpq_pkg::t_in                        i_data,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output obpq_pkg::t_out                            o_data,
    input  wire logic                                 i_cfg_we,
    input  wire logic [obpq_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [obpq_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int unsigned NS   = obpq_pkg::NUM_STAGES;
    localparam int unsigned RS_0 = obpq_pkg::XF_STAGES;
    localparam int unsigned FN_0 = obpq_pkg::XF_STAGES + obpq_pkg::RS_STAGES;

    obpq_pkg::t_cfg      r_cfg;
    logic [NS-1:0]       r_valid;
    logic [NS:0]         stage_en;
    obpq_pkg::t_local    xf_local;
    obpq_pkg::t_resolved rs_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pivot_x    <= '0;
            r_cfg.pivot_y    <= '0;
            r_cfg.box_width  <= '0;
            r_cfg.box_height <= '0;
            r_cfg.cos_angle  <= obpq_pkg::COS_RESET;
            r_cfg.sin_angle  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                obpq_pkg::CFG_PIVOT_X:    r_cfg.pivot_x    <= i_cfg_data;
                obpq_pkg::CFG_PIVOT_Y:    r_cfg.pivot_y    <= i_cfg_data;
                obpq_pkg::CFG_BOX_WIDTH:  r_cfg.box_width  <= i_cfg_data[30:0];
                obpq_pkg::CFG_BOX_HEIGHT: r_cfg.box_height <= i_cfg_data[30:0];
                obpq_pkg::CFG_COS_ANGLE:  r_cfg.cos_angle  <= i_cfg_data[17:0];
                obpq_pkg::CFG_SIN_ANGLE:  r_cfg.sin_angle  <= i_cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or its contents move on this cycle.
    always_comb begin
        stage_en[NS] = !i_stall;
        for (int k = NS - 1; k >= 0; k--) begin
            stage_en[k] = !r_valid[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (stage_en[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (stage_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    assign o_stall = !stage_en[0];
    assign o_valid = r_valid[NS-1];

    obpq_xform u_xform (
        .i_clk   (i_clk),
        .i_en    (stage_en[RS_0-1:0]),
        .i_data  (i_data),
        .i_cfg   (r_cfg),
        .o_local (xf_local)
    );

    obpq_resolve u_resolve (
        .i_clk   (i_clk),
        .i_en    (stage_en[FN_0-1:RS_0]),
        .i_local (xf_local),
        .i_cfg   (r_cfg),
        .o_res   (rs_res)
    );

    obpq_finish u_finish (
        .i_clk   (i_clk),
        .i_en    (stage_en[NS-1:FN_0]),
        .i_res   (rs_res),
        .i_cfg   (r_cfg),
        .o_data  (o_data)
    );

endmodule

`default_nettype wire

FILE: sv/obpq_xform.sv
// Rotation into box space: offset, four products, sums (three stages).
// Depends on obpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module obpq_xform (
    input  wire logic                                 i_clk,
    input  wire logic [obpq_pkg::XF_STAGES-1:0]       i_en,
    input  wire obpq_pkg::t_in                        i_data,
    input  wire obpq_pkg::t_cfg                       i_cfg,
    output obpq_pkg::t_local                          o_local
);

    logic signed [32:0] r_dx;
    logic signed [32:0] r_dy;
    logic        [30:0] r_r0;

    logic signed [50:0] r_dxc;
    logic signed [50:0] r_dys;
    logic signed [50:0] r_dyc;
    logic signed [50:0] r_dxs;
    logic               r_small_x1;
    logic               r_small_y1;
    logic        [30:0] r_hi_x1;
    logic        [30:0] r_hi_y1;
    logic        [30:0] r_r1;

    obpq_pkg::t_local   r_local;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_dx <= $signed({i_data.query_x[31], i_data.query_x})
                  - $signed({i_cfg.pivot_x[31], i_cfg.pivot_x});
            r_dy <= $signed({i_data.query_y[31], i_data.query_y})
                  - $signed({i_cfg.pivot_y[31], i_cfg.pivot_y});
            r_r0 <= i_data.agent_radius;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_dxc      <= r_dx * i_cfg.cos_angle;
            r_dys      <= r_dy * i_cfg.sin_angle;
            r_dyc      <= r_dy * i_cfg.cos_angle;
            r_dxs      <= r_dx * i_cfg.sin_angle;
            // size below 2r: target collapses to the axis midpoint
            r_small_x1 <= {1'b0, i_cfg.box_width}  < {r_r0, 1'b0};
            r_small_y1 <= {1'b0, i_cfg.box_height} < {r_r0, 1'b0};
            r_hi_x1    <= i_cfg.box_width  - r_r0;
            r_hi_y1    <= i_cfg.box_height - r_r0;
            r_r1       <= r_r0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_local.lx      <= $signed({r_dxc[50], r_dxc}) + $signed({r_dys[50], r_dys});
            r_local.ly      <= $signed({r_dyc[50], r_dyc}) - $signed({r_dxs[50], r_dxs});
            r_local.small_x <= r_small_x1;
            r_local.small_y <= r_small_y1;
            r_local.hi_x    <= r_hi_x1;
            r_local.hi_y    <= r_hi_y1;
            r_local.radius  <= r_r1;
        end
    end

    assign o_local = r_local;

endmodule

`default_nettype wire

FILE: sv/obpq_resolve.sv
// Containment, gap to the box and inset clamp per axis, then rounding to Q16.16.
// Depends on obpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module obpq_resolve (
    input  wire logic                                 i_clk,
    input  wire logic [obpq_pkg::RS_STAGES-1:0]       i_en,
    input  wire obpq_pkg::t_local                     i_local,
    input  wire obpq_pkg::t_cfg                       i_cfg,
    output obpq_pkg::t_resolved                       o_res
);

    // Distance from v to [0, size] in Q32.32.
    function automatic logic [51:0] axis_gap(input logic signed [51:0] v,
                                             input logic [30:0] size);
        logic [46:0] sq;
        logic [51:0] g;
        sq = {size, 16'b0};
        if (v[51]) begin
            g = 52'd0 - v;
        end else if (v[50:0] > {4'b0, sq}) begin
            g = v - {5'b0, sq};
        end else begin
            g = 52'd0;
        end
        return g;
    endfunction

    // Local target on one axis in Q32.32.
    function automatic logic [46:0] axis_target(input logic signed [51:0] v,
                                                input logic [30:0] size,
                                                input logic [30:0] r,
                                                input logic [30:0] hi,
                                                input logic narrow);
        logic [46:0] lo_q;
        logic [46:0] hi_q;
        logic [46:0] t;
        lo_q = {r, 16'b0};
        hi_q = {hi, 16'b0};
        if (narrow) begin
            t = {1'b0, size, 15'b0};
        end else if (v[51] || (v[50:0] < {4'b0, lo_q})) begin
            t = lo_q;
        end else if (v[50:0] > {4'b0, hi_q}) begin
            t = hi_q;
        end else begin
            t = v[46:0];
        end
        return t;
    endfunction

    logic        r_inside;
    logic [51:0] r_gap_x;
    logic [51:0] r_gap_y;
    logic [46:0] r_ax;
    logic [46:0] r_ay;

    logic        in_x;
    logic        in_y;
    logic [52:0] n_ex_sum;
    logic [52:0] n_ey_sum;
    logic [47:0] n_tx_sum;
    logic [47:0] n_ty_sum;

    obpq_pkg::t_resolved r_res;

    assign in_x = !i_local.lx[51] && (i_local.lx[50:0] <= {4'b0, i_cfg.box_width, 16'b0});
    assign in_y = !i_local.ly[51] && (i_local.ly[50:0] <= {4'b0, i_cfg.box_height, 16'b0});

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_inside <= in_x && in_y;
            r_gap_x  <= axis_gap(i_local.lx, i_cfg.box_width);
            r_gap_y  <= axis_gap(i_local.ly, i_cfg.box_height);
            r_ax     <= axis_target(i_local.lx, i_cfg.box_width, i_local.radius,
                                    i_local.hi_x, i_local.small_x);
            r_ay     <= axis_target(i_local.ly, i_cfg.box_height, i_local.radius,
                                    i_local.hi_y, i_local.small_y);
        end
    end

    // round to nearest, ties up
    assign n_ex_sum = {1'b0, r_gap_x} + 53'd32768;
    assign n_ey_sum = {1'b0, r_gap_y} + 53'd32768;
    assign n_tx_sum = {1'b0, r_ax} + 48'd32768;
    assign n_ty_sum = {1'b0, r_ay} + 48'd32768;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_res.in_box <= r_inside;
            r_res.ex     <= n_ex_sum[52:16];
            r_res.ey     <= n_ey_sum[52:16];
            r_res.tx     <= n_tx_sum[46:16];
            r_res.ty     <= n_ty_sum[46:16];
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

FILE: sv/obpq_finish.sv
// Squared distance with saturation and rotation of the target back to world space.
// Depends on obpq_pkg; ends in the output register.
`timescale 1ns / 1ps
`default_nettype none

module obpq_finish (
    input  wire logic                                 i_clk,
    input  wire logic [obpq_pkg::FN_STAGES-1:0]       i_en,
    input  wire obpq_pkg::t_resolved                  i_res,
    input  wire obpq_pkg::t_cfg                       i_cfg,
    output obpq_pkg::t_out                            o_data
);

    function automatic logic [62:0] sq_sat(input logic [36:0] e);
        logic [63:0] p;
        logic [62:0] q;
        p = e[31:0] * e[31:0];
        if ((|e[36:32]) || p[63]) begin
            q = obpq_pkg::DIST_MAX;
        end else begin
            q = p[62:0];
        end
        return q;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [36:0] v);
        logic [31:0] s;
        if ((&v[36:31]) || !(|v[36:31])) begin
            s = v[31:0];
        end else if (v[36]) begin
            s = obpq_pkg::TARGET_NEG_MAX;
        end else begin
            s = obpq_pkg::TARGET_POS_MAX;
        end
        return s;
    endfunction

    logic               r_inside5;
    logic        [62:0] r_sq_x;
    logic        [62:0] r_sq_y;
    logic signed [49:0] r_txc;
    logic signed [49:0] r_tys;
    logic signed [49:0] r_txs;
    logic signed [49:0] r_tyc;

    logic               r_inside6;
    logic        [62:0] r_dist;
    logic signed [35:0] r_wx;
    logic signed [35:0] r_wy;

    obpq_pkg::t_out     r_out;

    logic        [63:0] n_dist_sum;
    logic signed [51:0] n_vx;
    logic signed [51:0] n_vy;
    logic signed [36:0] n_px;
    logic signed [36:0] n_py;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_inside5 <= i_res.in_box;
            r_sq_x    <= sq_sat(i_res.ex);
            r_sq_y    <= sq_sat(i_res.ey);
            r_txc     <= $signed({1'b0, i_res.tx}) * i_cfg.cos_angle;
            r_tys     <= $signed({1'b0, i_res.ty}) * i_cfg.sin_angle;
            r_txs     <= $signed({1'b0, i_res.tx}) * i_cfg.sin_angle;
            r_tyc     <= $signed({1'b0, i_res.ty}) * i_cfg.cos_angle;
        end
    end

    assign n_dist_sum = {1'b0, r_sq_x} + {1'b0, r_sq_y};
    // rounding offset folded into the rotation sum
    assign n_vx = $signed({{2{r_txc[49]}}, r_txc}) - $signed({{2{r_tys[49]}}, r_tys})
                + 52'sd32768;
    assign n_vy = $signed({{2{r_txs[49]}}, r_txs}) + $signed({{2{r_tyc[49]}}, r_tyc})
                + 52'sd32768;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_inside6 <= r_inside5;
            r_dist    <= n_dist_sum[63] ? obpq_pkg::DIST_MAX : n_dist_sum[62:0];
            r_wx      <= n_vx[51:16];
            r_wy      <= n_vy[51:16];
        end
    end

    assign n_px = $signed({{5{i_cfg.pivot_x[31]}}, i_cfg.pivot_x}) + $signed({r_wx[35], r_wx});
    assign n_py = $signed({{5{i_cfg.pivot_y[31]}}, i_cfg.pivot_y}) + $signed({r_wy[35], r_wy});

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_out.inside_res   <= r_inside6;
            r_out.dist_squared <= r_dist;
            r_out.target_x     <= sat32(n_px);
            r_out.target_y     <= sat32(n_py);
        end
    end

    assign o_data = r_out;

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for oriented_box_point_query_top: directed and random queries
// checked against a fixed-point box predictor, with random stalls on both channels.
// Depends on obpq_pkg and the oriented_box_point_query_top RTL.

module tb;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned RANDOM_PER_SETTING = 125;
    localparam logic [obpq_pkg::CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [obpq_pkg::CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
    localparam longint ONE_Q16 = 65536;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_valid     = 1'b0;
    obpq_pkg::t_in                   i_data      = '0;
    logic                            o_stall;
    logic                            o_valid;
    logic                            i_stall     = 1'b0;
    obpq_pkg::t_out                  o_data;
    logic                            i_cfg_we    = 1'b0;
    logic [obpq_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [obpq_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    obpq_pkg::t_cfg  box_regs;
    obpq_pkg::t_out  pending_answers[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    int unsigned hold_req       = 0;
    int unsigned hold_seen      = 0;
    int unsigned hold_left      = 0;

    oriented_box_point_query_top DUT (.*);

    always #6 i_clk = ~i_clk;

    // Q32.32 to Q16.16, nearest with ties toward +infinity
    function automatic longint round_q16(input longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint axis_gap(input longint v, input longint hi);
        if (v < 0)
            return -v;
        if (v > hi)
            return v - hi;
        return 0;
    endfunction

    function automatic longint unsigned gap_square(input longint gap32);
        longint          e;
        longint unsigned p;
        e = round_q16(gap32);
        if (e <= 0)
            return 0;
        if (e >= 64'sh1_0000_0000)
            return {1'b0, obpq_pkg::DIST_MAX};
        p = longint'(unsigned'(e)) * longint'(unsigned'(e));
        if (p > {1'b0, obpq_pkg::DIST_MAX})
            return {1'b0, obpq_pkg::DIST_MAX};
        return p;
    endfunction

    // Clamp into [r, size - r], or take the midpoint when the axis is narrower than 2r
    function automatic longint inset_target(input longint v, input logic [30:0] size,
                                            input logic [30:0] radius);
        longint sz;
        longint rr;
        longint lo;
        longint hi;
        sz = longint'(size);
        rr = longint'(radius);
        if (sz < 2 * rr)
            return sz * 32768;
        lo = rr * ONE_Q16;
        hi = (sz - rr) * ONE_Q16;
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic obpq_pkg::t_out compute_answer(input obpq_pkg::t_in q,
                                                      input obpq_pkg::t_cfg b);
        longint          px, py, c, s, dx, dy, lx, ly, wq, hq, tx, ty, wx, wy;
        longint unsigned d, d2;
        longint unsigned dist_ceil;
        obpq_pkg::t_out  a;
        dist_ceil = {1'b0, obpq_pkg::DIST_MAX};
        px = longint'(signed'(b.pivot_x));
        py = longint'(signed'(b.pivot_y));
        c  = longint'(signed'(b.cos_angle));
        s  = longint'(signed'(b.sin_angle));
        dx = longint'(signed'(q.query_x)) - px;
        dy = longint'(signed'(q.query_y)) - py;
        lx = dx * c + dy * s;
        ly = dy * c - dx * s;
        wq = longint'(b.box_width) * ONE_Q16;
        hq = longint'(b.box_height) * ONE_Q16;
        d  = gap_square(axis_gap(lx, wq));
        d2 = gap_square(axis_gap(ly, hq));
        d  = (d > dist_ceil - d2) ? dist_ceil : d + d2;
        tx = round_q16(inset_target(lx, b.box_width, q.agent_radius));
        ty = round_q16(inset_target(ly, b.box_height, q.agent_radius));
        wx = clamp32(px + round_q16(tx * c - ty * s));
        wy = clamp32(py + round_q16(tx * s + ty * c));
        a.inside_res   = (lx >= 0) && (lx <= wq) && (ly >= 0) && (ly <= hq);
        a.dist_squared = d[62:0];
        a.target_x     = wx[31:0];
        a.target_y     = wy[31:0];
        return a;
    endfunction

    task automatic check_answer(input obpq_pkg::t_out got);
        obpq_pkg::t_out want;
        if (pending_answers.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
                $display("[%0t] result with no query outstanding: %p", $time, got);
            mismatch_count++;
        end else begin
            want = pending_answers.pop_front();
            if (got.inside_res !== want.inside_res || got.dist_squared !== want.dist_squared
                || got.target_x !== want.target_x || got.target_y !== want.target_y) begin
                if (mismatch_count < MAX_REPORTS) begin
                    $display("[%0t] mismatch inside exp %0b act %0b, dist exp %h act %h",
                             $time, want.inside_res, got.inside_res,
                             want.dist_squared, got.dist_squared);
                    $display("    target exp (%h, %h) act (%h, %h)",
                             want.target_x, want.target_y, got.target_x, got.target_y);
                end
                mismatch_count++;
            end
        end
    endtask

    // Result side: check each transfer, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall)
                check_answer(o_data);
            if (hold_seen != hold_req) begin
                hold_seen <= hold_req;
                hold_left <= HOLD_CYCLES - 1;
                i_stall   <= 1'b1;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_stall   <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[oriented_box_point_query_top] ERROR");
            $finish;
        end
    end

    task automatic send_query(input logic [31:0] qx, input logic [31:0] qy,
                              input logic [30:0] radius);
        obpq_pkg::t_in q;
        q.query_x      = qx;
        q.query_y      = qy;
        q.agent_radius = radius;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= q;
        do @(posedge i_clk); while (o_stall);
        pending_answers.push_back(compute_answer(q, box_regs));
    endtask

    task automatic write_reg(input logic [obpq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            obpq_pkg::CFG_PIVOT_X:    box_regs.pivot_x    = value;
            obpq_pkg::CFG_PIVOT_Y:    box_regs.pivot_y    = value;
            obpq_pkg::CFG_BOX_WIDTH:  box_regs.box_width  = value[30:0];
            obpq_pkg::CFG_BOX_HEIGHT: box_regs.box_height = value[30:0];
            obpq_pkg::CFG_COS_ANGLE:  box_regs.cos_angle  = value[17:0];
            obpq_pkg::CFG_SIN_ANGLE:  box_regs.sin_angle  = value[17:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Drop valid, drain every outstanding result, then let the pipeline settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (obpq_pkg::NUM_STAGES + 2) @(posedge i_clk);
    endtask

    task automatic program_box(input int unsigned kind);
        logic [31:0] px, py, w, h, c, s;
        logic [17:0] uc, us;
        case ($urandom_range(0, 5))
            0:       begin uc = 18'sd65536;  us = 18'sd0;      end
            1:       begin uc = 18'sd0;      us = 18'sd65536;  end
            2:       begin uc = 18'sd46341;  us = 18'sd46341;  end
            3:       begin uc = 18'sd56756;  us = -18'sd32768; end
            4:       begin uc = -18'sd65536; us = 18'sd0;      end
            default: begin uc = -18'sd46341; us = 18'sd46341;  end
        endcase
        px = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        py = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        c  = {14'($urandom), uc};
        s  = {14'($urandom), us};
        w  = {1'($urandom), 31'(($urandom_range(0, 40) << 16) | $urandom_range(0, 65535))};
        h  = {1'($urandom), 31'(($urandom_range(0, 40) << 16) | $urandom_range(0, 65535))};
        case (kind)
            0: ;
            1: begin
                px = $urandom;
                py = $urandom;
                w  = $urandom;
                h  = $urandom;
                c  = $urandom;
                s  = $urandom;
            end
            2: begin
                px = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                py = ~px;
                w  = 32'hFFFF_FFFF;
                h  = 32'h7FFF_FFFF;
                if ($urandom_range(1)) begin
                    c = 32'h0001_0000;
                    s = 32'hFFFF_0000;
                end else begin
                    c = 32'h0002_0000;
                    s = 32'h0001_FFFF;
                end
            end
            default: begin
                // segment or point box
                w = {1'($urandom), 31'd0};
                if ($urandom_range(1))
                    h = {1'($urandom), 31'd0};
            end
        endcase
        write_reg(obpq_pkg::CFG_PIVOT_X, px);
        write_reg(obpq_pkg::CFG_PIVOT_Y, py);
        write_reg(obpq_pkg::CFG_BOX_WIDTH, w);
        write_reg(obpq_pkg::CFG_BOX_HEIGHT, h);
        write_reg(obpq_pkg::CFG_COS_ANGLE, c);
        write_reg(obpq_pkg::CFG_SIN_ANGLE, s);
    endtask

    // Mostly points placed in box space around the box and rotated out; some pure noise
    task automatic send_random_query();
        longint      u, v, wl, hl, m, c, s, wx, wy;
        logic [31:0] qx, qy;
        logic [30:0] radius;
        int unsigned roll;
        int unsigned rsel;
        roll = $urandom_range(0, 99);
        rsel = $urandom_range(0, 9);
        wl   = longint'(box_regs.box_width);
        hl   = longint'(box_regs.box_height);
        if (roll < 20) begin
            qx     = $urandom;
            qy     = $urandom;
            radius = 31'($urandom);
        end else begin
            m = (wl + hl) / 4 + ONE_Q16;
            if (m > 64'sh2000_0000)
                m = 64'sh2000_0000;
            u = longint'($urandom_range(0, 32'(wl + 2 * m))) - m;
            v = longint'($urandom_range(0, 32'(hl + 2 * m))) - m;
            if (roll < 26)
                u = (roll % 2) ? wl * ONE_Q16 / ONE_Q16 : 0;
            else if (roll < 32)
                v = (roll % 2) ? hl : 0;
            c  = longint'(signed'(box_regs.cos_angle));
            s  = longint'(signed'(box_regs.sin_angle));
            wx = longint'(signed'(box_regs.pivot_x)) + ((u * c - v * s) >>> 16);
            wy = longint'(signed'(box_regs.pivot_y)) + ((u * s + v * c) >>> 16);
            qx = wx[31:0];
            qy = wy[31:0];
            if (rsel < 5)
                radius = 31'($urandom_range(0, 4 * 65536));
            else if (rsel < 9)
                radius = 31'($urandom_range(0, 32'((wl + hl) / 2 + ONE_Q16)));
            else
                radius = 31'($urandom);
        end
        send_query(qx, qy, radius);
    endtask

    task automatic test_reset_defaults();
        send_query(32'h0000_0000, 32'h0000_0000, 31'd0);
        send_query(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
        send_query(32'h8000_0000, 32'h7FFF_FFFF, 31'd0);
        send_query(32'h0001_0000, 32'hFFFF_0000, 31'd1);
        wait_idle();
    endtask

    // 10 x 6 box at (1, 2): interior, edges, corners, sides and the radius cases
    task automatic test_axis_aligned_box();
        write_reg(obpq_pkg::CFG_PIVOT_X, 32'h0001_0000);
        write_reg(obpq_pkg::CFG_PIVOT_Y, 32'h0002_0000);
        write_reg(obpq_pkg::CFG_BOX_WIDTH, 32'h000A_0000);
        write_reg(obpq_pkg::CFG_BOX_HEIGHT, 32'h0006_0000);
        write_reg(obpq_pkg::CFG_COS_ANGLE, 32'h0001_0000);
        write_reg(obpq_pkg::CFG_SIN_ANGLE, 32'h0000_0000);
        send_query(32'h0006_0000, 32'h0005_0000, 31'h0001_0000);
        send_query(32'h0001_0000, 32'h0005_0000, 31'd0);
        send_query(32'h000B_0000, 32'h0008_0000, 31'h0002_0000);
        send_query(32'h000C_8000, 32'h0009_4000, 31'h0001_0000);
        send_query(32'hFFFD_0000, 32'h0004_C000, 31'h0001_0000);
        send_query(32'h0005_0000, 32'h0000_0000, 31'h0000_8000);
        send_query(32'h0003_0000, 32'h0003_0000, 31'h0006_0000);
        send_query(32'h0003_0000, 32'h0007_0000, 31'h0003_0000);
        send_query(32'h0002_0000, 32'h0004_0000, 31'h0005_0000);
        send_query(32'h0001_0001, 32'h0002_0001, 31'd1);
        wait_idle();
    endtask

    task automatic test_rotation_and_saturation();
        // quarter turn
        write_reg(obpq_pkg::CFG_COS_ANGLE, 32'h0000_0000);
        write_reg(obpq_pkg::CFG_SIN_ANGLE, 32'h0001_0000);
        send_query(32'h0000_0000, 32'h0005_0000, 31'h0001_0000);
        send_query(32'h0001_0000, 32'h0002_0000, 31'd0);
        wait_idle();
        // rotation far beyond unit length, upper data bits ignored
        write_reg(obpq_pkg::CFG_COS_ANGLE, 32'hABC2_0000);
        write_reg(obpq_pkg::CFG_SIN_ANGLE, 32'h0001_FFFF);
        send_query(32'h0004_0000, 32'hFFFE_0000, 31'h0000_4000);
        send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        wait_idle();
        // world target pushed past both ends of the 32-bit range
        write_reg(obpq_pkg::CFG_PIVOT_X, 32'h7FFF_0000);
        write_reg(obpq_pkg::CFG_PIVOT_Y, 32'h8000_0000);
        write_reg(obpq_pkg::CFG_BOX_WIDTH, 32'hFFFF_FFFF);
        write_reg(obpq_pkg::CFG_BOX_HEIGHT, 32'h7FFF_FFFF);
        write_reg(obpq_pkg::CFG_COS_ANGLE, 32'h0001_0000);
        write_reg(obpq_pkg::CFG_SIN_ANGLE, 32'h0001_0000);
        send_query(32'h8000_0000, 32'h7FFF_FFFF, 31'd0);
        send_query(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
        wait_idle();
        // point box
        write_reg(obpq_pkg::CFG_PIVOT_X, 32'h0003_0000);
        write_reg(obpq_pkg::CFG_PIVOT_Y, 32'hFFFD_0000);
        write_reg(obpq_pkg::CFG_BOX_WIDTH, 32'h8000_0000);
        write_reg(obpq_pkg::CFG_BOX_HEIGHT, 32'h0000_0000);
        write_reg(obpq_pkg::CFG_SIN_ANGLE, 32'h0000_0000);
        send_query(32'h0003_0000, 32'hFFFD_0000, 31'd0);
        send_query(32'h0005_0000, 32'h0001_0000, 31'h0001_0000);
        wait_idle();
    endtask

    task automatic test_spare_index();
        write_reg(CFG_SPARE_6, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_7, 32'hFFFF_FFFF);
        send_query(32'h0003_0000, 32'hFFFD_0000, 31'd0);
        send_query(32'h0002_8000, 32'hFFFC_0000, 31'h0000_8000);
        wait_idle();
    endtask

    task automatic run_random_phase(input int unsigned tx_pct, input int unsigned rx_pct);
        send_idle_pct = tx_pct;
        recv_idle_pct <= rx_pct;
        for (int k = 0; k < 4; k++) begin
            program_box(k);
            for (int n = 0; n < RANDOM_PER_SETTING; n++)
                send_random_query();
            wait_idle();
        end
    endtask

    // Hold the result side off long enough for the pipeline to fill and stall its input
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        program_box(0);
        hold_req <= hold_req + 1;
        for (int n = 0; n < 60; n++)
            send_random_query();
        wait_idle();
    endtask

    initial begin
        box_regs.pivot_x    = '0;
        box_regs.pivot_y    = '0;
        box_regs.box_width  = '0;
        box_regs.box_height = '0;
        box_regs.cos_angle  = obpq_pkg::COS_RESET;
        box_regs.sin_angle  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_axis_aligned_box();
        test_rotation_and_saturation();
        test_spare_index();
        run_random_phase(29, 77);
        run_random_phase(77, 29);
        run_random_phase(0, 0);
        test_output_backpressure();
        if (mismatch_count == 0 && pending_answers.size() == 0)
            $display("[oriented_box_point_query_top] OK");
        else
            $display("[oriented_box_point_query_top] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
sv/obpq_pkg.sv
sv/obpq_xform.sv
sv/obpq_resolve.sv
sv/obpq_finish.sv
sv/oriented_box_point_query_top.sv
tb/tb.sv
